/* design/pattern_delta_decoder_assert.svh */
// ----------------------------------------------------------------------------
// pattern_delta_decoder_assert
// assertion macros shared by the pattern delta decoder modules
// ----------------------------------------------------------------------------
`ifndef PATTERN_DELTA_DECODER_ASSERT_SVH
`define PATTERN_DELTA_DECODER_ASSERT_SVH

// same-cycle implication
`define PDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pattern delta decoder assertion failed");

// next-cycle implication
`define PDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pattern delta decoder assertion failed");

`endif

/* design/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// pdd_pkg
// types and constants of the pattern delta decoder
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int unsigned ChanW    = 7;
  localparam int unsigned RowW     = 10;
  localparam int unsigned CfgRowW  = 11;
  localparam int unsigned NumLanes = 6;
  localparam int unsigned LaneW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 2;

  localparam int unsigned DefMaxChannels = 128;
  localparam int unsigned DefMaxRows     = 1024;

  localparam logic [ChanW-1:0]   NumChannelsRst = 7'd4;
  localparam logic [CfgRowW-1:0] NumRowsRst     = 11'd64;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  localparam logic KIND_CELL    = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  localparam logic [NumLanes-1:0] ItemBits = 6'h3f;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_CHANNELS = 2'd0,
    CFG_NUM_ROWS     = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [RowW-1:0]  row;
    logic [ChanW-1:0] channel;
    logic [7:0]       note;
    logic [7:0]       instrument;
    logic [7:0]       volume_command;
    logic [7:0]       volume_value;
    logic [7:0]       effect_command;
    logic [7:0]       effect_param;
    logic             pattern_done;
  } out_t;

  typedef logic [NumLanes-1:0][7:0] cell_t;

  // requests from the parser to the cell store
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [ChanW-1:0] wr_chan;
    logic [LaneW-1:0] wr_lane;
    logic [7:0]       wr_byte;
    logic             rd_en;
    logic [ChanW-1:0] rd_chan;
  } store_req_t;

  // result stage, aligned with the store read data
  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [RowW-1:0]     row;
    logic [ChanW-1:0]    channel;
    logic                done;
    logic [NumLanes-1:0] mask;
    cell_t               work;
  } res_t;

endpackage

/* design/pdd_parser.sv */
// ----------------------------------------------------------------------------
// pdd_parser
// byte parser: entry state machine, row counter, skip counter and result stage
// ----------------------------------------------------------------------------
`include "pattern_delta_decoder_assert.svh"

module pdd_parser #(
  parameter int unsigned MAX_CHANNELS = pdd_pkg::DefMaxChannels,
  parameter int unsigned MAX_ROWS     = pdd_pkg::DefMaxRows
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  pdd_pkg::in_t                      item_i,
  input  logic [pdd_pkg::ChanW-1:0]         num_channels_i,
  input  logic [pdd_pkg::CfgRowW-1:0]       num_rows_i,
  output pdd_pkg::store_req_t               req_o,
  output pdd_pkg::res_t                     res_o
);

  localparam int unsigned RowCw = $clog2(MAX_ROWS + 1);
  localparam logic [pdd_pkg::ChanW:0]     MaxChan = (pdd_pkg::ChanW + 1)'(MAX_CHANNELS);
  localparam logic [pdd_pkg::CfgRowW-1:0] MaxRows = pdd_pkg::CfgRowW'(MAX_ROWS);

  typedef enum logic [4:0] {
    PH_CHAN = 5'b00001,
    PH_MASK = 5'b00010,
    PH_ITEM = 5'b00100,
    PH_LEN  = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [pdd_pkg::ChanW-1:0]     chan_q, chan_d;
  logic [6:0]                    mask_q, mask_d;
  logic [7:0]                    skip_q, skip_d;
  logic [RowCw-1:0]              row_q, row_d;
  pdd_pkg::cell_t                work_q, work_d;
  logic [pdd_pkg::NumLanes-1:0]  wmask_q, wmask_d;
  pdd_pkg::res_t                 res_q, res_d;

  logic [7:0]                    b;
  logic [pdd_pkg::ChanW-1:0]     ch_new, cur_ch;
  logic                          chan_ok;
  logic [pdd_pkg::CfgRowW-1:0]   lim, row_ext, row_inc_ext;
  logic [RowCw-1:0]              row_inc;
  logic                          finished;
  logic [pdd_pkg::LaneW-1:0]     lane;
  logic                          close;

  assign b           = item_i.data_byte;
  assign ch_new      = (b[6:0] != 7'd0) ? b[6:0] - 7'd1 : 7'd0;
  assign cur_ch      = (phase_q == PH_CHAN) ? ch_new : chan_q;
  assign chan_ok     = (cur_ch < num_channels_i) && ({1'b0, cur_ch} < MaxChan);
  assign lim         = (num_rows_i > MaxRows) ? MaxRows : num_rows_i;
  assign row_ext     = pdd_pkg::CfgRowW'(row_q);
  assign row_inc     = row_q + RowCw'(1);
  assign row_inc_ext = pdd_pkg::CfgRowW'(row_inc);
  assign finished    = row_ext >= lim;

  // lowest pending item lane
  always_comb begin
    lane = '0;
    for (int i = pdd_pkg::NumLanes - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        lane = pdd_pkg::LaneW'(i);
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    mask_d  = mask_q;
    skip_d  = skip_q;
    row_d   = row_q;
    work_d  = work_q;
    wmask_d = wmask_q;
    close   = 1'b0;
    req_o   = '0;
    res_d   = '0;
    res_d.row = row_ext[pdd_pkg::RowW-1:0];
    if (accept_i) begin
      if (item_i.operation == pdd_pkg::OP_BEGIN) begin
        phase_d     = PH_CHAN;
        chan_d      = '0;
        mask_d      = '0;
        skip_d      = '0;
        row_d       = '0;
        req_o.clear = 1'b1;
      end else if (!finished) begin
        unique case (phase_q)
          PH_CHAN: begin
            if (b == 8'd0) begin
              res_d.valid = 1'b1;
              res_d.kind  = pdd_pkg::KIND_ROW_END;
              res_d.mask  = pdd_pkg::ItemBits;
              res_d.done  = row_inc_ext == lim;
              row_d       = row_inc;
            end else begin
              chan_d  = ch_new;
              wmask_d = '0;
              if (b[7]) begin
                phase_d = PH_MASK;
              end else begin
                mask_d = '0;
                close  = 1'b1;
              end
            end
          end
          PH_MASK: begin
            mask_d = b[6:0];
            if ((b[5:0] & pdd_pkg::ItemBits) == '0) begin
              close = 1'b1;
            end else begin
              phase_d = PH_ITEM;
            end
          end
          PH_ITEM: begin
            work_d[lane]  = b;
            wmask_d[lane] = 1'b1;
            mask_d[lane]  = 1'b0;
            if (chan_ok) begin
              req_o.wr_en   = 1'b1;
              req_o.wr_chan = cur_ch;
              req_o.wr_lane = lane;
              req_o.wr_byte = b;
            end
            if ((mask_d[5:0] & pdd_pkg::ItemBits) == '0) begin
              close = 1'b1;
            end
          end
          PH_LEN: begin
            skip_d  = b;
            phase_d = (b == 8'd0) ? PH_CHAN : PH_SKIP;
          end
          PH_SKIP: begin
            if (skip_q != 8'd0) begin
              skip_d = skip_q - 8'd1;
            end
            if (skip_d == 8'd0) begin
              phase_d = PH_CHAN;
            end
          end
          default: begin
            phase_d = PH_CHAN;
          end
        endcase
        if (close) begin
          if (chan_ok) begin
            res_d.valid   = 1'b1;
            res_d.kind    = pdd_pkg::KIND_CELL;
            res_d.channel = cur_ch;
            res_d.mask    = wmask_d;
            res_d.work    = work_d;
            req_o.rd_en   = 1'b1;
            req_o.rd_chan = cur_ch;
          end
          phase_d = mask_d[6] ? PH_LEN : PH_CHAN;
          mask_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHAN;
      chan_q  <= '0;
      mask_q  <= '0;
      skip_q  <= '0;
      row_q   <= '0;
      res_q   <= '0;
    end else begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      mask_q  <= mask_d;
      skip_q  <= skip_d;
      row_q   <= row_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    wmask_q <= wmask_d;
  end

  assign res_o = res_q;

  `PDD_ASSERT_IMPL(a_item_pending, clk_i, rst_ni, phase_q == PH_ITEM, mask_q[5:0] != 6'd0)
  `PDD_ASSERT_IMPL(a_skip_nonzero, clk_i, rst_ni, phase_q == PH_SKIP, skip_q != 8'd0)
  `PDD_ASSERT_NEXT(a_begin_clears, clk_i, rst_ni,
                   accept_i && item_i.operation == pdd_pkg::OP_BEGIN,
                   phase_q == PH_CHAN && row_q == '0 && !res_q.valid)

endmodule

/* design/pdd_cell_store.sv */
// ----------------------------------------------------------------------------
// pdd_cell_store
// per-channel memory of the last six cell values, with per-channel valid bits
// ----------------------------------------------------------------------------
module pdd_cell_store #(
  parameter int unsigned MAX_CHANNELS = pdd_pkg::DefMaxChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdd_pkg::store_req_t req_i,
  output pdd_pkg::cell_t      rdata_o,
  output logic                rvalid_o
);

  localparam int unsigned ChanAw = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  pdd_pkg::cell_t           mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]  valid_q;
  pdd_pkg::cell_t           rdata_q;
  logic                     rvalid_q;
  pdd_pkg::cell_t           fresh;
  logic [ChanAw-1:0]        wr_addr, rd_addr;

  assign wr_addr = req_i.wr_chan[ChanAw-1:0];
  assign rd_addr = req_i.rd_chan[ChanAw-1:0];

  // first write since begin: other lanes read as zero
  always_comb begin
    fresh = '0;
    fresh[req_i.wr_lane] = req_i.wr_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      if (valid_q[wr_addr]) begin
        mem[wr_addr][req_i.wr_lane] <= req_i.wr_byte;
      end else begin
        mem[wr_addr] <= fresh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q  <= mem[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

/* design/pdd_out_fifo.sv */
// ----------------------------------------------------------------------------
// pdd_out_fifo
// three-entry result queue in front of the output channel
// ----------------------------------------------------------------------------
`include "pattern_delta_decoder_assert.svh"

module pdd_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pdd_pkg::out_t                 push_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pdd_pkg::out_t                 out_data_o,
  output logic [pdd_pkg::FifoCntW-1:0]  count_o
);

  localparam logic [pdd_pkg::FifoPtrW-1:0] LastPtr = pdd_pkg::FifoPtrW'(pdd_pkg::FifoDepth - 1);

  pdd_pkg::out_t                  entry_q [pdd_pkg::FifoDepth];
  logic [pdd_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [pdd_pkg::FifoCntW-1:0]   count_q;
  logic                           pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_data_o = entry_q[rd_ptr_q];
  assign count_o    = count_q;

  `PDD_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni,
                   push_i && count_q == pdd_pkg::FifoCntW'(pdd_pkg::FifoDepth), pop)
  `PDD_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop, count_q == $past(count_q) + 1'b1)
  `PDD_ASSERT_NEXT(a_count_down, clk_i, rst_ni, pop && !push_i, count_q == $past(count_q) - 1'b1)

endmodule

/* design/pattern_delta_decoder.sv */
// ----------------------------------------------------------------------------
// pattern_delta_decoder
// decodes a delta-compressed tracker pattern into cell writes and row ends
// ----------------------------------------------------------------------------
// One stream byte is taken per clock cycle, back to back, while the input is
// not stalled; each byte yields at most one transaction, which is registered
// in a result stage and then pushed into a three-entry output queue, from
// which it is offered on the output. The input stalls only while the result
// stage and the queue together hold three transactions, so the output can be
// held off for three transactions before the input backs up. The 128 x 48-bit
// cell store is one write port for item bytes and one read port for cell
// writes; a begin transaction clears it through per-channel valid bits, with
// no clearing pass after reset.
module pattern_delta_decoder #(
  parameter int unsigned MAX_CHANNELS = pdd_pkg::DefMaxChannels,
  parameter int unsigned MAX_ROWS     = pdd_pkg::DefMaxRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pdd_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pdd_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pdd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pdd_pkg::CfgRowW-1:0]   cfg_data_i
);

  logic [pdd_pkg::ChanW-1:0]    num_channels_q;
  logic [pdd_pkg::CfgRowW-1:0]  num_rows_q;
  logic                         in_accept;
  pdd_pkg::store_req_t          req;
  pdd_pkg::res_t                res;
  pdd_pkg::cell_t               rdata, cell_val;
  logic                         rvalid;
  pdd_pkg::out_t                result;
  logic [pdd_pkg::FifoCntW-1:0] fifo_count;
  logic [pdd_pkg::FifoCntW:0]   in_flight;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= pdd_pkg::NumChannelsRst;
      num_rows_q     <= pdd_pkg::NumRowsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pdd_pkg::cfg_idx_e'(cfg_index_i))
        pdd_pkg::CFG_NUM_CHANNELS: num_channels_q <= cfg_data_i[pdd_pkg::ChanW-1:0];
        pdd_pkg::CFG_NUM_ROWS:     num_rows_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_flight  = {1'b0, fifo_count} + {{pdd_pkg::FifoCntW{1'b0}}, res.valid};
  assign in_stall_o = in_flight >= (pdd_pkg::FifoCntW + 1)'(pdd_pkg::FifoDepth);
  assign in_accept  = in_valid_i && !in_stall_o;

  pdd_parser #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .item_i         (in_data_i),
    .num_channels_i (num_channels_q),
    .num_rows_i     (num_rows_q),
    .req_o          (req),
    .res_o          (res)
  );

  pdd_cell_store #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  // bytes written during the entry override the stored values
  always_comb begin
    for (int k = 0; k < pdd_pkg::NumLanes; k++) begin
      cell_val[k] = res.mask[k] ? res.work[k] : (rvalid ? rdata[k] : 8'h00);
    end
  end

  always_comb begin
    result.kind           = res.kind;
    result.row            = res.row;
    result.channel        = res.channel;
    result.note           = cell_val[0];
    result.instrument     = cell_val[1];
    result.volume_command = cell_val[2];
    result.volume_value   = cell_val[3];
    result.effect_command = cell_val[4];
    result.effect_param   = cell_val[5];
    result.pattern_done   = res.done;
  end

  pdd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res.valid),
    .push_data_i (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_count)
  );

endmodule
